### hw/rtl/sirdig_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirdig_pkg: shared definitions for the signed integer to radix digits block
// Widths, character codes, register indexes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sirdig_pkg;

   localparam int MAX_RADIX_DEF = 16;
   localparam int ALPHA_SLOTS   = 16;
   localparam int NUM_W         = 32;
   localparam int CHAR_W        = 8;
   localparam int RADIX_W       = 5;
   localparam int DIGIT_W       = $clog2(ALPHA_SLOTS);
   localparam int SLICE_BITS    = 8;
   localparam int SLICES        = NUM_W / SLICE_BITS;
   localparam int SLICE_CNT_W   = $clog2(SLICES);
   localparam int DIGITS_MAX    = NUM_W;
   localparam int DIGIT_IDX_W   = $clog2(DIGITS_MAX);
   localparam int DIGIT_CNT_W   = $clog2(DIGITS_MAX + 1);
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 64;

   localparam logic [CHAR_W-1:0] CHAR_MINUS     = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS      = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_LO  = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_END = 8'd127;
   localparam logic [CHAR_W-1:0] CHAR_NONE      = 8'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIX_LENGTH  = 2'd0,
      CSR_ALPHABET_LOW  = 2'd1,
      CSR_ALPHABET_HIGH = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic check;
      logic div;
      logic emit_sign;
      logic emit_digit;
      logic emit_bad;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic len_bad;
      logic chk_bad;
      logic chk_done;
      logic div_end;
      logic div_stop;
      logic neg;
      logic emit_last;
   } stat_type;

endpackage

### hw/rtl/sirdig_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirdig_ctrl: sequencing state machine
// Steps through alphabet checking, digit division and character emission,
// driving the datapath by command bundle.
// ----------------------------------------------------------------------------
module sirdig_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output sirdig_pkg::cmd_type  cmd,
   input  sirdig_pkg::stat_type stat
);
   import sirdig_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_DIVIDE = 6'b000100,
      ST_SIGN   = 6'b001000,
      ST_EMIT   = 6'b010000,
      ST_BAD    = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // Length is judged before any character, so an index beyond the
            // alphabet never decides the outcome.
            if (stat.len_bad || stat.chk_bad) begin
               state_in = ST_BAD;
            end else if (stat.chk_done) begin
               state_in = ST_DIVIDE;
            end else begin
               cmd.check = 1'b1;
            end
         end
         ST_DIVIDE: begin
            cmd.div = 1'b1;
            if (stat.div_end && stat.div_stop) begin
               state_in = stat.neg ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            cmd.emit_sign = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_digit = 1'b1;
            if (stat.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_BAD: begin
            cmd.emit_bad = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### hw/rtl/sirdig_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirdig_dp: configuration registers, checker, divider and output register
// Holds the alphabet, checks one character a cycle, divides by the radix
// eight dividend bits a cycle and keeps the digits for emission.
// ----------------------------------------------------------------------------
module sirdig_dp #(
   parameter int MAX_RADIX = sirdig_pkg::MAX_RADIX_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [sirdig_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sirdig_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic signed [sirdig_pkg::NUM_W-1:0]    req_number,
   input  sirdig_pkg::cmd_type                    cmd,
   output sirdig_pkg::stat_type                   stat,
   output logic                                   rsp_valid,
   output logic [sirdig_pkg::CHAR_W-1:0]          rsp_character,
   output logic                                   rsp_last,
   output logic                                   rsp_invalid_base
);
   import sirdig_pkg::*;

   logic [RADIX_W-1:0]                     radix_ff;
   logic [ALPHA_SLOTS-1:0][CHAR_W-1:0]     alpha_ff;

   logic                                   neg_ff;
   logic [NUM_W-1:0]                       mag_ff;
   logic [DIGIT_W-1:0]                     chk_idx_ff;
   logic [SLICE_CNT_W-1:0]                 slice_ff;
   logic [DIGIT_W-1:0]                     rem_ff;
   logic                                   quot_nz_ff;
   logic [DIGIT_CNT_W-1:0]                 nd_ff;
   logic [DIGIT_W-1:0]                     digits_ff [DIGITS_MAX];

   logic                                   rsp_valid_ff;
   logic [CHAR_W-1:0]                      rsp_char_ff;
   logic                                   rsp_last_ff;
   logic                                   rsp_inv_ff;

   logic [CHAR_W-1:0]                      chk_char;
   logic                                   chk_dup;
   logic [SLICE_BITS-1:0]                  qbits;
   logic [DIGIT_W-1:0]                     rem_in;
   logic                                   slice_last;
   logic                                   quot_zero;
   logic [DIGIT_IDX_W-1:0]                 emit_idx;
   logic [NUM_W-1:0]                       num_u;

   // Configuration writes; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= '0;
         alpha_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_RADIX_LENGTH:  radix_ff <= csr_wdata[RADIX_W-1:0];
            CSR_ALPHABET_LOW:  alpha_ff[ALPHA_SLOTS/2-1:0] <= csr_wdata;
            CSR_ALPHABET_HIGH: alpha_ff[ALPHA_SLOTS-1:ALPHA_SLOTS/2] <= csr_wdata;
            CSR_UNUSED: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Character check: the current character against the printable range and
   // the sign characters, and against every later character in the alphabet.
   always_comb begin
      chk_char = alpha_ff[chk_idx_ff];
      chk_dup  = 1'b0;
      for (int j = 0; j < ALPHA_SLOTS; j++) begin
         if ((DIGIT_W'(j) > chk_idx_ff) && (RADIX_W'(j) < radix_ff) &&
             (alpha_ff[j] == chk_char)) begin
            chk_dup = 1'b1;
         end
      end
   end

   assign stat.len_bad  = (radix_ff < RADIX_W'(2)) || (32'(radix_ff) > MAX_RADIX) ||
                          (32'(radix_ff) > ALPHA_SLOTS);
   assign stat.chk_bad  = (chk_char < CHAR_PRINT_LO) || (chk_char >= CHAR_PRINT_END) ||
                          (chk_char == CHAR_PLUS) || (chk_char == CHAR_MINUS) || chk_dup;
   assign stat.chk_done = ({1'b0, chk_idx_ff} == (radix_ff - RADIX_W'(1)));

   // One division slice: eight restoring steps on a remainder below the radix.
   always_comb begin
      logic [RADIX_W-1:0] r;
      r = (slice_ff == '0) ? '0 : {1'b0, rem_ff};
      qbits = '0;
      for (int k = 0; k < SLICE_BITS; k++) begin
         r = {r[DIGIT_W-1:0], mag_ff[NUM_W-1-k]};
         if (r >= radix_ff) begin
            qbits[SLICE_BITS-1-k] = 1'b1;
            r = r - radix_ff;
         end
      end
      rem_in = r[DIGIT_W-1:0];
   end

   assign slice_last    = (slice_ff == SLICE_CNT_W'(SLICES - 1));
   assign quot_zero     = !(quot_nz_ff || (|qbits));
   assign stat.div_end  = slice_last;
   assign stat.div_stop = quot_zero || (nd_ff == DIGIT_CNT_W'(DIGITS_MAX - 1));
   assign stat.neg      = neg_ff;
   assign stat.emit_last = (nd_ff == DIGIT_CNT_W'(1));

   assign emit_idx = DIGIT_IDX_W'(nd_ff - DIGIT_CNT_W'(1));
   assign num_u    = req_number;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff     <= num_u[NUM_W-1];
         mag_ff     <= num_u[NUM_W-1] ? (NUM_W'(0) - num_u) : num_u;
         chk_idx_ff <= '0;
         slice_ff   <= '0;
         nd_ff      <= '0;
      end else begin
         if (cmd.check) begin
            chk_idx_ff <= chk_idx_ff + DIGIT_W'(1);
         end
         if (cmd.div) begin
            // Quotient bits enter at the bottom; after the last slice the
            // register holds the whole quotient.
            mag_ff     <= {mag_ff[NUM_W-SLICE_BITS-1:0], qbits};
            rem_ff     <= rem_in;
            slice_ff   <= slice_ff + SLICE_CNT_W'(1);
            quot_nz_ff <= (slice_ff == '0) ? (|qbits) : (quot_nz_ff || (|qbits));
            if (slice_last) begin
               digits_ff[nd_ff[DIGIT_IDX_W-1:0]] <= rem_in;
               nd_ff <= nd_ff + DIGIT_CNT_W'(1);
            end
         end
         if (cmd.emit_digit) begin
            nd_ff <= nd_ff - DIGIT_CNT_W'(1);
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_sign || cmd.emit_digit || cmd.emit_bad;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sign) begin
         rsp_char_ff <= CHAR_MINUS;
         rsp_last_ff <= 1'b0;
         rsp_inv_ff  <= 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_char_ff <= alpha_ff[digits_ff[emit_idx]];
         rsp_last_ff <= stat.emit_last;
         rsp_inv_ff  <= 1'b0;
      end else if (cmd.emit_bad) begin
         rsp_char_ff <= CHAR_NONE;
         rsp_last_ff <= 1'b1;
         rsp_inv_ff  <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_character    = rsp_char_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_invalid_base = rsp_inv_ff;

endmodule

### hw/rtl/signed_int_to_radix_digits.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits: signed 32-bit integer to text in a set radix
// Writes a number as characters of a configured alphabet, most significant
// digit first, with a leading minus sign for negative values.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  -----------------------------------------
//  request   start / busy           req_number (signed, 32 bits)
//  response  rsp_valid (strobe)     rsp_character, rsp_last, rsp_invalid_base
//  control   csr_valid / csr_ready  csr_index, csr_wdata
//
// A request transaction completes on a clock edge with start high and busy
// low. The alphabet is then checked one character per cycle, the magnitude
// is divided by the radix eight bits per cycle, and one character is sent
// per cycle. Reset is synchronous and active high; it returns the controller
// to idle and clears the configuration registers. Responses are strobed for
// one cycle and the receiver cannot stall them. Control writes are always
// taken; the user must make them only while the block is idle, as the block
// itself does not enforce this.
//
module signed_int_to_radix_digits #(
   parameter int MAX_RADIX = sirdig_pkg::MAX_RADIX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [sirdig_pkg::NUM_W-1:0] req_number,
   output logic                                rsp_valid,
   output logic [sirdig_pkg::CHAR_W-1:0]       rsp_character,
   output logic                                rsp_last,
   output logic                                rsp_invalid_base,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sirdig_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sirdig_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sirdig_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Control writes are taken as soon as they are offered, so the port never pushes back.
   assign csr_ready = 1'b1;

   // The controller owns sequencing; it sees only the start strobe and the
   // status bundle, and steers the datapath through the command bundle.
   sirdig_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   // The datapath holds the configuration, the checker, the radix divider,
   // the digit store and the response register.
   sirdig_dp #(
      .MAX_RADIX (MAX_RADIX)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_number       (req_number),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .rsp_invalid_base (rsp_invalid_base)
   );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for signed_int_to_radix_digits
// Sends signed 32-bit numbers under a series of alphabets and compares every
// strobed character against a local prediction of the expected text, in
// order. The alphabet checks, the extremes of the number range and random
// alphabets with random numbers are all exercised.
// ----------------------------------------------------------------------------
module tb_top;
   import sirdig_pkg::*;

   localparam logic signed [NUM_W-1:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [NUM_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
   // Random numbers to send after the directed part.
   localparam int RANDOM_ITEMS = 420;
   // Settling time before a register write, once the last character is in.
   localparam int SETTLE_CYCLES = 24;
   // Quiet time at the end: longer than the slowest conversion.
   localparam int DRAIN_CYCLES = 200;
   // Worst case is roughly 500 numbers, none slower than the slowest conversion,
   // plus the register writes, so 20 ms of simulated time is a wide margin.
   localparam int TIMEOUT_NS = 20_000_000;

   // One expected character of a number's text.
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              final_char;
      logic              bad_base;
   } text_char_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic signed [NUM_W-1:0]  req_number;
   logic                     rsp_valid;
   logic [CHAR_W-1:0]        rsp_character;
   logic                     rsp_last;
   logic                     rsp_invalid_base;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;

   // Local copy of the configuration registers, updated on each accepted
   // write transaction.
   logic [RADIX_W-1:0]       cfg_radix;
   logic [CSR_DATA_W-1:0]    cfg_alpha_lo;
   logic [CSR_DATA_W-1:0]    cfg_alpha_hi;

   // Characters still to arrive, oldest first.
   text_char_type            pending_chars[$];
   text_char_type            want;

   bit                       steady_sender;
   int unsigned              numbers_sent;
   int unsigned              chars_checked;
   int unsigned              alphabets_loaded;
   int unsigned              failures;

   signed_int_to_radix_digits DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_number       (req_number),
      .rsp_valid        (rsp_valid),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .rsp_invalid_base (rsp_invalid_base),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Alphabet character at a given slot; slots 0 to 7 live in the low word.
   function automatic logic [CHAR_W-1:0] alpha_at(input logic [DIGIT_W-1:0] slot);
      if (slot[3]) begin
         return cfg_alpha_hi[8*slot[2:0] +: 8];
      end
      return cfg_alpha_lo[8*slot[2:0] +: 8];
   endfunction

   // The alphabet is usable only with 2 to 16 characters, all printable,
   // none of them a sign, and no character appearing twice. Slots beyond the
   // configured length play no part.
   function automatic bit alphabet_valid();
      int                n;
      logic [CHAR_W-1:0] c;
      n = int'(cfg_radix);
      if (n < 2 || n > MAX_RADIX_DEF || n > ALPHA_SLOTS) begin
         return 1'b0;
      end
      for (int i = 0; i < n; i++) begin
         c = alpha_at(DIGIT_W'(i));
         if (c < CHAR_PRINT_LO || c >= CHAR_PRINT_END || c == CHAR_PLUS ||
             c == CHAR_MINUS) begin
            return 1'b0;
         end
         for (int j = i + 1; j < n; j++) begin
            if (alpha_at(DIGIT_W'(j)) == c) begin
               return 1'b0;
            end
         end
      end
      return 1'b1;
   endfunction

   // Queues the text expected for one accepted number. The magnitude is
   // taken as an unsigned value, so the most negative number needs no
   // special handling.
   function automatic void predict_text(input logic signed [NUM_W-1:0] value);
      logic [NUM_W-1:0]   mag;
      logic [NUM_W-1:0]   radix;
      logic [DIGIT_W-1:0] digit_vals [DIGITS_MAX];
      int                 count;
      if (!alphabet_valid()) begin
         pending_chars.push_back('{CHAR_NONE, 1'b1, 1'b1});
         return;
      end
      mag = value;
      if (value[NUM_W-1]) begin
         mag = '0 - mag;
      end
      radix = NUM_W'(cfg_radix);
      count = 0;
      do begin
         digit_vals[count] = DIGIT_W'(mag % radix);
         count++;
         mag = mag / radix;
      end while (mag != 0 && count < DIGITS_MAX);
      if (value[NUM_W-1]) begin
         pending_chars.push_back('{CHAR_MINUS, 1'b0, 1'b0});
      end
      for (int i = count - 1; i >= 0; i--) begin
         pending_chars.push_back('{alpha_at(digit_vals[i]), i == 0, 1'b0});
      end
   endfunction

   // ------------------------------------------------------------------------
   // Checking: every strobed character is compared with the oldest one
   // waiting. The receiver cannot stall, so each strobe is one transaction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_chars.size() == 0) begin
            failures++;
            $display("%0t: unexpected character: expected none, got %h last %b invalid %b",
                     $time, rsp_character, rsp_last, rsp_invalid_base);
         end else begin
            want = pending_chars.pop_front();
            chars_checked++;
            if (rsp_character !== want.ch) begin
               failures++;
               $display("%0t: character: expected %h, got %h",
                        $time, want.ch, rsp_character);
            end
            if (rsp_last !== want.final_char) begin
               failures++;
               $display("%0t: last flag: expected %b, got %b",
                        $time, want.final_char, rsp_last);
            end
            if (rsp_invalid_base !== want.bad_base) begin
               failures++;
               $display("%0t: invalid flag: expected %b, got %b",
                        $time, want.bad_base, rsp_invalid_base);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Driving. Inputs change on the falling edge; handshakes are judged on
   // the rising edge, where busy and csr_ready still hold their old values.
   // ------------------------------------------------------------------------

   // Offers one number and waits until the block takes it. Start is left
   // high afterwards so that back-to-back numbers are offered without a gap; a
   // random gap lowers it on one falling edge and raises it on a later one.
   task automatic send_number(input logic signed [NUM_W-1:0] value);
      if (!steady_sender && $urandom_range(0, 99) < 28) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      start      <= 1'b1;
      req_number <= value;
      do @(posedge clock); while (busy);
      predict_text(value);
      numbers_sent++;
   endtask

   // Stops sending and waits for every outstanding character, then lets the
   // block settle so that a register write finds it idle.
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // One register write transaction. Only the modelled registers change the
   // local copy; a write to the unused index must be ignored by the block.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RADIX_LENGTH:  cfg_radix    = data[RADIX_W-1:0];
         CSR_ALPHABET_LOW:  cfg_alpha_lo = data;
         CSR_ALPHABET_HIGH: cfg_alpha_hi = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_radix(input int n);
      wait_idle();
      write_reg(CSR_RADIX_LENGTH, {$urandom, $urandom} & ~64'h1F | 64'(n));
   endtask

   // Loads a complete alphabet. The spare upper bits of the radix register
   // carry random data, which the block must drop, and now and then a write
   // to the unused index is slipped in first.
   task automatic write_alphabet(input int n, input logic [CHAR_W-1:0] set_chars [ALPHA_SLOTS]);
      logic [CSR_DATA_W-1:0] lo;
      logic [CSR_DATA_W-1:0] hi;
      logic [CSR_DATA_W-1:0] upper;
      for (int i = 0; i < 8; i++) begin
         lo[8*i +: 8] = set_chars[i];
         hi[8*i +: 8] = set_chars[i + 8];
      end
      upper = {$urandom, $urandom};
      wait_idle();
      if ($urandom_range(0, 3) == 0) begin
         write_reg(CSR_UNUSED, ~upper);
      end
      write_reg(CSR_ALPHABET_LOW, lo);
      write_reg(CSR_ALPHABET_HIGH, hi);
      write_reg(CSR_RADIX_LENGTH, {upper[CSR_DATA_W-1:RADIX_W], RADIX_W'(n)});
      alphabets_loaded++;
   endtask

   task automatic write_alphabet_text(input string s);
      logic [CHAR_W-1:0] set_chars [ALPHA_SLOTS];
      for (int i = 0; i < ALPHA_SLOTS; i++) begin
         set_chars[i] = (i < s.len()) ? s[i] : 8'h00;
      end
      write_alphabet(s.len(), set_chars);
   endtask

   // Builds a random alphabet of distinct printable characters, sign-free,
   // with the lengths 2 and 16 favoured. When asked for a broken one, a
   // single defect is planted: a repeat, a non-printable character, a sign
   // or a length outside 2 to 16.
   task automatic load_random_alphabet(input bit broken);
      logic [CHAR_W-1:0] set_chars [ALPHA_SLOTS];
      logic [CHAR_W-1:0] c;
      int                n;
      int                slot;
      bit                clash;
      n = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16 : 2)
                                      : $urandom_range(2, 16);
      for (int i = 0; i < ALPHA_SLOTS; i++) begin
         set_chars[i] = CHAR_W'($urandom_range(0, 255));
      end
      for (int i = 0; i < n; i++) begin
         do begin
            c = CHAR_W'($urandom_range(32, 126));
            clash = (c == CHAR_PLUS || c == CHAR_MINUS);
            for (int j = 0; j < i; j++) begin
               if (set_chars[j] == c) clash = 1'b1;
            end
         end while (clash);
         set_chars[i] = c;
      end
      if (broken) begin
         case ($urandom_range(0, 3))
            0: begin
               slot = $urandom_range(1, n - 1);
               set_chars[slot] = set_chars[$urandom_range(0, slot - 1)];
            end
            1: set_chars[$urandom_range(0, n - 1)] =
                  CHAR_W'($urandom_range(0, 1) ? $urandom_range(0, 31)
                                               : $urandom_range(127, 255));
            2: set_chars[$urandom_range(0, n - 1)] =
                  $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
            default: n = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                              : $urandom_range(17, 31);
         endcase
      end
      write_alphabet(n, set_chars);
   endtask

   // Random numbers: a spread of digit counts by shifting out a random
   // number of bits, small values around zero, and the range extremes.
   function automatic logic signed [NUM_W-1:0] pick_number();
      logic [NUM_W-1:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0: return INT_MIN;
               1: return INT_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         1: return NUM_W'($signed($urandom_range(0, 40)) - 20);
         2, 3: begin
            raw = raw >> $urandom_range(0, 31);
            return $urandom_range(0, 1) ? -$signed(raw) : $signed(raw);
         end
         default: return raw;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // The configuration registers clear on reset, so the empty alphabet must be rejected.
   task automatic test_reset_state();
      send_number('0);
      send_number(INT_MIN);
   endtask

   // Each way an alphabet can fail validation, one number apiece.
   task automatic test_alphabet_checks();
      write_alphabet_text("7");
      send_number(32'sd5);
      write_alphabet_text("0123456789ABCDEF");
      set_radix(17);
      send_number(-32'sd17);
      set_radix(31);
      send_number(32'sd31);
      write_alphabet_text("01+3");
      send_number(32'sd9);
      write_alphabet_text("0-23");
      send_number(-32'sd9);
      write_alphabet_text("0120");
      send_number(32'sd100);
      // A control character inside the alphabet: slot 2 holds 0x1F.
      wait_idle();
      write_reg(CSR_ALPHABET_LOW, 64'h0000_0000_331F_3130);
      send_number(32'sd7);
      // DEL in the top slot of a full sixteen-character alphabet.
      write_alphabet_text("0123456789ABCDEF");
      wait_idle();
      write_reg(CSR_ALPHABET_HIGH, {8'h7F, cfg_alpha_hi[55:0]});
      send_number(32'sd7);
   endtask

   // Extremes of the number range under decimal, binary and a sixteen-
   // character alphabet that starts with space and ends with tilde.
   task automatic test_directed_numbers();
      write_alphabet_text("0123456789");
      send_number('0);
      send_number(32'sd1);
      send_number(-32'sd1);
      send_number(INT_MAX);
      send_number(INT_MIN);
      send_number(32'sd1_000_000_000);
      // A write to the unused index must leave the alphabet untouched.
      wait_idle();
      write_reg(CSR_UNUSED, '1);
      send_number(-32'sd42);
      // Binary: the most negative number gives the longest text, 33 chars.
      write_alphabet_text("01");
      send_number(INT_MIN);
      send_number(INT_MAX);
      send_number('0);
      write_alphabet_text(" 123456789abcde~");
      send_number(-32'sd1);
      send_number(INT_MIN);
      send_number(32'sh1234_5678);
      write_alphabet_text("~ ");
      send_number(-32'sd5);
   endtask

   // Random alphabets, mostly valid, each followed by a burst of random
   // numbers. Two early phases send with no gaps at all, and now and then
   // the sender holds off until every character has come back.
   task automatic test_random_conversions();
      int total;
      int phase;
      int burst;
      bit broken;
      total = 0;
      phase = 0;
      while (total < RANDOM_ITEMS) begin
         broken = ($urandom_range(0, 99) < 15);
         load_random_alphabet(broken);
         steady_sender = (phase == 3 || phase == 4);
         burst = broken ? $urandom_range(2, 5) : $urandom_range(15, 40);
         repeat (burst) begin
            if ($urandom_range(0, 49) == 0) wait_idle();
            send_number(pick_number());
            total++;
         end
         phase++;
      end
      steady_sender = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sequence: reset, then the tests in turn, then a drain long enough for the
   // slowest conversion before the verdict.
   // ------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_number       = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_RADIX_LENGTH;
      csr_wdata        = '0;
      cfg_radix        = '0;
      cfg_alpha_lo     = '0;
      cfg_alpha_hi     = '0;
      steady_sender    = 1'b0;
      numbers_sent     = 0;
      chars_checked    = 0;
      alphabets_loaded = 0;
      failures         = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_alphabet_checks();
      test_directed_numbers();
      test_random_conversions();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Converted %0d numbers under %0d alphabets, %0d characters compared.",
               numbers_sent, alphabets_loaded, chars_checked);
      if (failures == 0 && pending_chars.size() == 0) begin
         $display("signed_int_to_radix_digits: match");
      end else begin
         $display("%0d errors, %0d characters never arrived.",
                  failures, pending_chars.size());
         $display("signed_int_to_radix_digits: mismatch");
      end
      $finish;
   end

   // Watchdog in case the block hangs.
   initial begin
      #(TIMEOUT_NS);
      $display("Timed out with %0d characters outstanding.", pending_chars.size());
      $display("signed_int_to_radix_digits: mismatch");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/sirdig_pkg.sv
hw/rtl/sirdig_ctrl.sv
hw/rtl/sirdig_dp.sv
hw/rtl/signed_int_to_radix_digits.sv
sim/tb_top.sv
